// File: hdl/prescaled_reload_timer_core_defines.svh
// Assertion helpers shared by the timer RTL.
// Both sample on clk_i and stay quiet while rst_ni is low.
`ifndef PRESCALED_RELOAD_TIMER_CORE_DEFINES_SVH
`define PRESCALED_RELOAD_TIMER_CORE_DEFINES_SVH

`define PRT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check on the cycle after the antecedent.
`define PRT_ASSERT_NEXT(label, pre, post, msg) \
  `PRT_ASSERT(label, (pre) |=> (post), msg)

`endif

// File: hdl/prt_pkg.sv
package prt_pkg;

  localparam int unsigned DataW = 16;
  localparam int unsigned PscW  = 16;

  typedef enum logic [1:0] {
    CmdTick  = 2'd0,
    CmdWrite = 2'd1,
    CmdRead  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    RegCtrl   = 2'd0,
    RegStatus = 2'd1,
    RegCount  = 2'd2,
    RegEvent  = 2'd3
  } reg_sel_e;

  typedef enum logic [1:0] {
    CfgPrescaler = 2'd0,
    CfgReload    = 2'd1,
    CfgIrqEn     = 2'd2,
    CfgOvfOnly   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [PscW-1:0]  prescaler;
    logic [DataW-1:0] reload;
    logic             irq_en;
    logic             ovf_only;
  } cfg_t;

  typedef struct packed {
    cmd_e             cmd;
    reg_sel_e         sel;
    logic [DataW-1:0] data;
  } item_t;

  typedef struct packed {
    logic             running;
    logic             irq;
    logic [DataW-1:0] read_data;
  } result_t;

endpackage

// File: hdl/prescaled_reload_timer_core.sv
// Prescaled auto-reload up-counting timer.
// Input stream: each item is a tick, a register write or a register read;
// s_axis_tuser carries the command and the register select, s_axis_tdata
// the write value. Every item gives exactly one result on the output stream:
// read data, the interrupt level and the running bit after that item.
// The APB port holds prescaler, reload, interrupt enable and overflow-only
// option at byte addresses 0, 4, 8 and 12; pready is tied high.
// A result appears in the cycle after its item is accepted.
// Throughput: one item per cycle when not stalled; the whole state update is
// one pass of logic from the timer registers into the result register.
// When the output stalls, the result register holds and s_axis_tready
// drops until the result is taken; a result leaving in the same cycle
// lets a new item in.
// Reset clears both counts, enable, one-pulse and update flag, the
// prescaler to 0 and reload to all ones; no result is pending after reset.
`include "prescaled_reload_timer_core_defines.svh"

module prescaled_reload_timer_core #(
  parameter int unsigned COUNTER_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [15:0] write_data
  input  logic [3:0]  s_axis_tuser,  // [1:0] cmd, [3:2] reg_select
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [15:0] read_data, [16] irq, [17] running
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import prt_pkg::*;

  cfg_t     cfg_q;
  cfg_idx_e cfg_idx;
  logic     cfg_wr;
  item_t    item;
  logic     in_accept;
  result_t  res;
  logic     out_valid_q, out_valid_d;
  result_t  out_data_q;

  assign pready  = 1'b1;
  assign cfg_idx = cfg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prescaler <= '0;
      cfg_q.reload    <= '1;
      cfg_q.irq_en    <= 1'b0;
      cfg_q.ovf_only  <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        CfgPrescaler: cfg_q.prescaler <= pwdata[PscW-1:0];
        CfgReload:    cfg_q.reload    <= pwdata[DataW-1:0];
        CfgIrqEn:     cfg_q.irq_en    <= pwdata[0];
        CfgOvfOnly:   cfg_q.ovf_only  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      CfgPrescaler: prdata = 32'(cfg_q.prescaler);
      CfgReload:    prdata = 32'(cfg_q.reload);
      CfgIrqEn:     prdata = 32'(cfg_q.irq_en);
      CfgOvfOnly:   prdata = 32'(cfg_q.ovf_only);
      default:      prdata = '0;
    endcase
  end

  assign item.cmd  = cmd_e'(s_axis_tuser[1:0]);
  assign item.sel  = reg_sel_e'(s_axis_tuser[3:2]);
  assign item.data = s_axis_tdata;

  // take a new item whenever the result register is free or draining
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  prt_timer #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_timer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(in_accept),
    .item_i      (item),
    .cfg_i       (cfg_q),
    .result_o    (res)
  );

  assign out_valid_d = in_accept || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_data_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_data_q.running, out_data_q.irq, out_data_q.read_data};

  `PRT_ASSERT(a_ready_when_empty, !out_valid_q |-> s_axis_tready,
    "input blocked with empty result register")
  `PRT_ASSERT_NEXT(a_accept_gives_result, in_accept, m_axis_tvalid,
    "accepted item produced no result")
  `PRT_ASSERT(a_no_overwrite, m_axis_tvalid && !m_axis_tready |-> !s_axis_tready,
    "input accepted over a stalled result")

endmodule

// File: hdl/prt_timer.sv
`include "prescaled_reload_timer_core_defines.svh"

module prt_timer #(
  parameter int unsigned COUNTER_WIDTH = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            item_valid_i,
  input  prt_pkg::item_t  item_i,
  input  prt_pkg::cfg_t   cfg_i,
  output prt_pkg::result_t result_o
);
  import prt_pkg::*;

  localparam int unsigned CmpW = (COUNTER_WIDTH > DataW) ? COUNTER_WIDTH : DataW;

  logic [PscW-1:0]          psc_q, psc_d;
  logic [COUNTER_WIDTH-1:0] cnt_q, cnt_d;
  logic                     en_q, en_d;
  logic                     op_q, op_d;
  logic                     flag_q, flag_d;
  logic [DataW-1:0]         rd;
  logic [CmpW-1:0]          cnt_ext;
  logic [CmpW-1:0]          reload_ext;
  logic [CmpW-1:0]          data_ext;
  logic                     psc_wrap;
  logic                     cnt_wrap;

  assign cnt_ext    = CmpW'(cnt_q);
  assign reload_ext = CmpW'(cfg_i.reload);
  assign data_ext   = CmpW'(item_i.data);
  assign psc_wrap   = (psc_q >= cfg_i.prescaler);
  // a counter written above reload wraps on its next step as well
  assign cnt_wrap   = (cnt_ext >= reload_ext);

  always_comb begin
    psc_d  = psc_q;
    cnt_d  = cnt_q;
    en_d   = en_q;
    op_d   = op_q;
    flag_d = flag_q;
    rd     = '0;
    if (item_valid_i) begin
      unique case (item_i.cmd)
        CmdTick: begin
          if (en_q) begin
            if (psc_wrap) begin
              psc_d = '0;
              // zero reload holds the counter
              if (cfg_i.reload != '0) begin
                if (cnt_wrap) begin
                  cnt_d  = '0;
                  flag_d = 1'b1;
                  if (op_q) begin
                    en_d = 1'b0;
                  end
                end else begin
                  cnt_d = cnt_q + COUNTER_WIDTH'(1);
                end
              end
            end else begin
              psc_d = psc_q + PscW'(1);
            end
          end
        end
        CmdWrite: begin
          unique case (item_i.sel)
            RegCtrl: begin
              en_d = item_i.data[0];
              op_d = item_i.data[1];
            end
            RegStatus: flag_d = flag_q & item_i.data[0];
            RegCount:  cnt_d  = data_ext[COUNTER_WIDTH-1:0];
            RegEvent: begin
              if (item_i.data[0]) begin
                psc_d = '0;
                cnt_d = '0;
                if (!cfg_i.ovf_only) begin
                  flag_d = 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
        CmdRead: begin
          unique case (item_i.sel)
            RegCtrl:   rd = {{(DataW-2){1'b0}}, op_q, en_q};
            RegStatus: rd = {{(DataW-1){1'b0}}, flag_q};
            RegCount:  rd = cnt_ext[DataW-1:0];
            RegEvent:  rd = '0;
            default:   rd = '0;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      psc_q  <= '0;
      cnt_q  <= '0;
      en_q   <= 1'b0;
      op_q   <= 1'b0;
      flag_q <= 1'b0;
    end else begin
      psc_q  <= psc_d;
      cnt_q  <= cnt_d;
      en_q   <= en_d;
      op_q   <= op_d;
      flag_q <= flag_d;
    end
  end

  assign result_o.read_data = rd;
  assign result_o.irq       = flag_d & cfg_i.irq_en;
  assign result_o.running   = en_d;

  `PRT_ASSERT_NEXT(a_stopped_tick_holds,
    item_valid_i && item_i.cmd == CmdTick && !en_q,
    $stable(psc_q) && $stable(cnt_q) && $stable(flag_q),
    "tick changed counts while stopped")
  `PRT_ASSERT_NEXT(a_zero_reload_holds,
    item_valid_i && item_i.cmd == CmdTick && cfg_i.reload == '0,
    $stable(cnt_q) && $stable(flag_q),
    "counter moved with zero reload")
  `PRT_ASSERT_NEXT(a_one_pulse_stops,
    item_valid_i && item_i.cmd == CmdTick && en_q && op_q && psc_wrap &&
      cfg_i.reload != '0 && cnt_wrap,
    !en_q && flag_q && cnt_q == '0,
    "one-pulse wrap did not stop the timer")

endmodule

// File: tb/tb_prescaled_reload_timer_core.sv
module tb_prescaled_reload_timer_core;
  import prt_pkg::*;

  localparam logic [1:0] CmdUnused = 2'd3;
  localparam int unsigned IdleLimit = 3000;

  typedef struct packed {
    logic [1:0]  cmd;
    reg_sel_e    sel;
    logic [15:0] data;
  } timer_op_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;  // [15:0] write_data
  logic [3:0]  s_axis_tuser = '0;  // [1:0] cmd, [3:2] reg_select
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;       // [15:0] read_data, [16] irq, [17] running
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  prescaled_reload_timer_core u_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  always #5 clk_i = ~clk_i;

  // Timer shadow: configuration and state as the block should hold them.
  cfg_t        shadow_cfg = '{prescaler: '0, reload: 16'hFFFF, irq_en: 1'b0, ovf_only: 1'b0};
  logic [15:0] psc_cnt = '0;
  logic [15:0] cnt_val = '0;
  logic        en_bit = 1'b0;
  logic        op_bit = 1'b0;
  logic        upd_flag = 1'b0;

  timer_op_t   pending_ops[$];
  result_t     results_due[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  logic        item_taken = 1'b0;
  bit          steady_send = 1'b0;
  int unsigned hold_req = 0;

  function automatic result_t timer_apply(timer_op_t op);
    result_t res;
    res = '0;
    case (op.cmd)
      CmdTick: begin
        if (en_bit) begin
          if (psc_cnt >= shadow_cfg.prescaler) begin
            psc_cnt = '0;
            // reload of zero holds the counter
            if (shadow_cfg.reload != '0) begin
              if (cnt_val >= shadow_cfg.reload) begin
                cnt_val  = '0;
                upd_flag = 1'b1;
                if (op_bit) en_bit = 1'b0;
              end else begin
                cnt_val = cnt_val + 16'd1;
              end
            end
          end else begin
            psc_cnt = psc_cnt + 16'd1;
          end
        end
      end
      CmdWrite: begin
        case (op.sel)
          RegCtrl: begin
            en_bit = op.data[0];
            op_bit = op.data[1];
          end
          RegStatus: upd_flag = upd_flag & op.data[0];
          RegCount:  cnt_val = op.data;
          RegEvent: begin
            if (op.data[0]) begin
              psc_cnt = '0;
              cnt_val = '0;
              if (!shadow_cfg.ovf_only) upd_flag = 1'b1;
            end
          end
        endcase
      end
      CmdRead: begin
        case (op.sel)
          RegCtrl:   res.read_data = {14'd0, op_bit, en_bit};
          RegStatus: res.read_data = {15'd0, upd_flag};
          RegCount:  res.read_data = cnt_val;
          RegEvent:  res.read_data = '0;
        endcase
      end
      default: ;
    endcase
    res.irq     = upd_flag & shadow_cfg.irq_en;
    res.running = en_bit;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got_v, logic [15:0] want_v);
    mismatches++;
    $display("%0t: %s mismatch: got 0x%0h, want 0x%0h", $time, what, got_v, want_v);
  endtask

  task automatic add_op(logic [1:0] cmd, reg_sel_e sel, logic [15:0] data);
    pending_ops.push_back('{cmd: cmd, sel: sel, data: data});
  endtask

  function automatic timer_op_t random_op();
    timer_op_t   op;
    int unsigned pick;
    pick    = $urandom_range(0, 99);
    op.data = 16'($urandom);
    op.sel  = reg_sel_e'($urandom_range(0, 3));
    op.cmd  = CmdWrite;
    if (pick < 55) begin
      op.cmd = CmdTick;
    end else if (pick < 65) begin
      // mostly keep the timer running
      op.sel = RegCtrl;
      if ($urandom_range(0, 4) != 0) op.data[0] = 1'b1;
    end else if (pick < 70) begin
      op.sel = RegStatus;
    end else if (pick < 77) begin
      op.sel = RegCount;
      if ($urandom_range(0, 1) != 0)
        op.data = shadow_cfg.reload + 16'($urandom_range(0, 3)) - 16'd1;
    end else if (pick < 82) begin
      op.sel = RegEvent;
    end else if (pick < 95) begin
      op.cmd = CmdRead;
    end else begin
      op.cmd = CmdUnused;
    end
    return op;
  endfunction

  task automatic apb_write_cfg(cfg_idx_e idx, logic [15:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    if (idx == CfgPrescaler || idx == CfgReload)
      pwdata <= {16'($urandom), val};
    else
      pwdata <= {31'($urandom), val[0]};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      CfgPrescaler: shadow_cfg.prescaler = val;
      CfgReload:    shadow_cfg.reload = val;
      CfgIrqEn:     shadow_cfg.irq_en = val[0];
      CfgOvfOnly:   shadow_cfg.ovf_only = val[0];
    endcase
  endtask

  task automatic wait_drained();
    wait (pending_ops.size() == 0 && results_due.size() == 0);
    @(negedge clk_i);
  endtask

  task automatic run_phase(logic [15:0] psc, logic [15:0] rel, logic irq_en, logic ovf_only,
                           int unsigned n_ops, int unsigned hold_cycles, bit no_gaps);
    apb_write_cfg(CfgPrescaler, psc);
    apb_write_cfg(CfgReload, rel);
    apb_write_cfg(CfgIrqEn, {15'd0, irq_en});
    apb_write_cfg(CfgOvfOnly, {15'd0, ovf_only});
    steady_send = no_gaps;
    repeat (n_ops) pending_ops.push_back(random_op());
    if (hold_cycles != 0) begin
      @(posedge clk_i);
      hold_req = hold_cycles;
    end
    wait_drained();
  endtask

  // Sender: bursts of random length separated by random gaps, none when steady_send is set.
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && !item_taken) begin
        // hold the offered item until it is taken
      end else if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pending_ops[0].data;
        s_axis_tuser  <= {pending_ops[0].sel, pending_ops[0].cmd};
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          if (steady_send || $urandom_range(0, 2) == 0) gap_left = 0;
          else gap_left = $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: its own stall pattern, plus a long hold-off on request.
  int unsigned hold_left = 0;
  int unsigned mode_left = 0;
  int unsigned rx_mode = 0;
  int unsigned rx_cycle = 0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      rx_cycle++;
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = $urandom_range(0, 2);
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        case (rx_mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
          default: m_axis_tready <= (rx_cycle % 5 != 0);
        endcase
      end
    end
  end

  // Check results first, then predict the item taken at the same edge.
  result_t got_res;
  result_t want_res;

  always @(posedge clk_i) begin
    item_taken <= s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_res = result_t'(m_axis_tdata[17:0]);
        if (results_due.size() == 0) begin
          report_mismatch("unexpected result", got_res.read_data, '0);
        end else begin
          want_res = results_due.pop_front();
          if (got_res.read_data !== want_res.read_data)
            report_mismatch("read_data", got_res.read_data, want_res.read_data);
          if (got_res.irq !== want_res.irq)
            report_mismatch("irq", {15'd0, got_res.irq}, {15'd0, want_res.irq});
          if (got_res.running !== want_res.running)
            report_mismatch("running", {15'd0, got_res.running}, {15'd0, want_res.running});
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        results_due.push_back(timer_apply(pending_ops.pop_front()));
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable) || !rst_ni)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset defaults: prescaler 0, reload all ones.
    add_op(CmdRead, RegCtrl, 16'h0000);
    add_op(CmdRead, RegStatus, 16'h0000);
    add_op(CmdRead, RegCount, 16'h0000);
    add_op(CmdRead, RegEvent, 16'hFFFF);
    add_op(CmdWrite, RegCtrl, 16'h0001);
    add_op(CmdTick, RegCtrl, 16'h0000);
    add_op(CmdWrite, RegCount, 16'hFFFF);
    add_op(CmdTick, RegStatus, 16'hFFFF);
    add_op(CmdRead, RegStatus, 16'h0000);
    add_op(CmdWrite, RegStatus, 16'h0001);
    add_op(CmdWrite, RegStatus, 16'hFFFE);
    add_op(CmdWrite, RegEvent, 16'hFFFE);
    add_op(CmdWrite, RegEvent, 16'h0001);
    add_op(CmdRead, RegCount, 16'h0000);
    add_op(CmdUnused, RegCount, 16'hFFFF);
    add_op(CmdWrite, RegCtrl, 16'hFFFF);
    add_op(CmdWrite, RegCount, 16'hFFFE);
    add_op(CmdTick, RegCtrl, 16'h0000);
    add_op(CmdTick, RegCtrl, 16'h0000);
    add_op(CmdTick, RegCtrl, 16'h0000);
    add_op(CmdRead, RegCtrl, 16'h0000);
    add_op(CmdRead, RegCount, 16'h0000);
    add_op(CmdWrite, RegCtrl, 16'h0000);
    wait_drained();

    // reload of zero with overflow-only set
    run_phase(16'd0, 16'd0, 1'b1, 1'b1, 60, 0, 1'b0);
    run_phase(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 40, 0, 1'b0);
    // long receiver hold-off: the block fills and stalls its input
    run_phase(16'd1, 16'd5, 1'b1, 1'b0, 140, 300, 1'b0);
    run_phase(16'd3, 16'd1, 1'b1, 1'b1, 110, 0, 1'b1);
    run_phase(16'd0, 16'd2, 1'b0, 1'b0, 130, 0, 1'b0);

    repeat (4) @(posedge clk_i);
    if (results_due.size() != 0)
      report_mismatch("missing results", 16'(results_due.size()), '0);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/prt_pkg.sv
hdl/prt_timer.sv
hdl/prescaled_reload_timer_core.sv
tb/tb_prescaled_reload_timer_core.sv
